>>> src/qte_pkg.sv
// ============================================================================
// qte_pkg
// Shared widths, constants and the CORDIC arctangent table.
// ============================================================================
package qte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEPS_MAX        = 24;

    localparam int QW  = 16;   // quaternion component width
    localparam int PW  = 32;   // product width
    localparam int SW  = 36;   // sum width
    localparam int CW  = 38;   // CORDIC x/y width
    localparam int ZW  = 20;   // angle accumulator width, Q16
    localparam int AW  = 17;   // rounded angle width, Q13
    localparam int SLW = 29;   // sine width once unclamped
    localparam int RW  = 58;   // square root work width
    localparam int SQRT_STAGES = 29;

    localparam int HALF_PI_Q16 = 102944;
    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;

    typedef logic signed [CW-1:0] cxy_t;
    typedef logic signed [ZW-1:0] ang_t;

    function automatic ang_t atan_q16(input int idx);
        ang_t v;
        case (idx)
            0:  v = ang_t'(51472);
            1:  v = ang_t'(30385);
            2:  v = ang_t'(16055);
            3:  v = ang_t'(8150);
            4:  v = ang_t'(4091);
            5:  v = ang_t'(2047);
            6:  v = ang_t'(1024);
            7:  v = ang_t'(512);
            8:  v = ang_t'(256);
            9:  v = ang_t'(128);
            10: v = ang_t'(64);
            11: v = ang_t'(32);
            12: v = ang_t'(16);
            13: v = ang_t'(8);
            14: v = ang_t'(4);
            15: v = ang_t'(2);
            16: v = ang_t'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/qte_cordic.sv
// ============================================================================
// qte_cordic
// Pipelined CORDIC vectoring atan2, one rotation per stage, Q13 result.
// ============================================================================
module qte_cordic #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              ce,
    input  qte_pkg::cxy_t                     y_in,
    input  qte_pkg::cxy_t                     x_in,
    output logic signed [qte_pkg::AW-1:0]     angle
);

    qte_pkg::cxy_t x_reg [0:CORDIC_STEPS];
    qte_pkg::cxy_t y_reg [0:CORDIC_STEPS];
    qte_pkg::ang_t z_reg [0:CORDIC_STEPS];
    logic          zero_reg [0:CORDIC_STEPS];
    logic signed [qte_pkg::AW-1:0] angle_reg;

    qte_pkg::ang_t z_rnd;

    // quadrant fold into the right half plane
    always_ff @(posedge aclk) begin
        if (ce) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                if (y_in >= 0) begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= qte_pkg::ang_t'(qte_pkg::HALF_PI_Q16);
                end else begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -qte_pkg::ang_t'(qte_pkg::HALF_PI_Q16);
                end
            end else begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (ce) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + qte_pkg::atan_q16(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - qte_pkg::atan_q16(i);
                end
            end
        end
    end

    assign z_rnd = (z_reg[CORDIC_STEPS] + qte_pkg::ang_t'(4)) >>> 3;

    always_ff @(posedge aclk) begin
        if (ce) begin
            angle_reg <= zero_reg[CORDIC_STEPS] ? '0 : z_rnd[qte_pkg::AW-1:0];
        end
    end

    assign angle = angle_reg;

endmodule

>>> src/quaternion_to_euler_core.sv
// ============================================================================
// quaternion_to_euler_core
// Unit quaternion (Q2.14) to roll / yaw in radians (Q3.13) and pitch (Q2.13).
// ============================================================================
//  channel  | direction | fields
//  s_       | in        | quat_x, quat_y, quat_z, quat_w
//  m_       | out       | roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
//  One transaction per cycle while the output is not stalled; the pitch path runs
//  through the 29-stage bit-per-stage square root into the pitch CORDIC pipeline.
//  Reset (aresetn low, synchronous) clears the valid bits only.
//  A stalled output freezes the whole pipeline; in-flight transactions hold.
// ============================================================================
module quaternion_to_euler_core #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_roll_angle,
    output logic signed [14:0] m_pitch_angle,
    output logic signed [15:0] m_yaw_angle,
    output logic               m_pitch_clamped
);

    localparam int ALIGN = qte_pkg::SQRT_STAGES + 1;   // sq stage + root stages
    localparam int CLAT  = CORDIC_STEPS + 2;
    localparam int LAT   = 3 + qte_pkg::SQRT_STAGES + CLAT + 1;

    logic ce;
    assign ce      = m_ready || !m_valid;
    assign s_ready = ce;

    // valid bits travel with the data
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end
    assign m_valid = vld_reg[LAT-1];

    // ---- stage 1: products -------------------------------------------------
    logic signed [qte_pkg::PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qte_pkg::PW-1:0] wz_reg, xy_reg, wy_reg, zx_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            wx_reg <= s_quat_w * s_quat_x;
            yz_reg <= s_quat_y * s_quat_z;
            xx_reg <= s_quat_x * s_quat_x;
            yy_reg <= s_quat_y * s_quat_y;
            zz_reg <= s_quat_z * s_quat_z;
            wz_reg <= s_quat_w * s_quat_z;
            xy_reg <= s_quat_x * s_quat_y;
            wy_reg <= s_quat_w * s_quat_y;
            zx_reg <= s_quat_z * s_quat_x;
        end
    end

    // ---- stage 2: doubled sums ---------------------------------------------
    localparam logic signed [qte_pkg::SW-1:0] ONE_Q28 = qte_pkg::SW'(1) <<< 28;

    logic signed [qte_pkg::SW-1:0] rsn_next, rcs_next, ysn_next, ycs_next, s_next;
    logic signed [qte_pkg::SW-1:0] rsn_reg, rcs_reg, ysn_reg, ycs_reg;
    logic signed [qte_pkg::SLW-1:0] slo_reg;
    logic clamp_reg, spos_reg;

    always_comb begin
        rsn_next = (qte_pkg::SW'(wx_reg) + qte_pkg::SW'(yz_reg)) <<< 1;
        rcs_next = ONE_Q28 - ((qte_pkg::SW'(xx_reg) + qte_pkg::SW'(yy_reg)) <<< 1);
        ysn_next = (qte_pkg::SW'(wz_reg) + qte_pkg::SW'(xy_reg)) <<< 1;
        ycs_next = ONE_Q28 - ((qte_pkg::SW'(yy_reg) + qte_pkg::SW'(zz_reg)) <<< 1);
        s_next   = (qte_pkg::SW'(wy_reg) - qte_pkg::SW'(zx_reg)) <<< 1;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rsn_reg   <= rsn_next;
            rcs_reg   <= rcs_next;
            ysn_reg   <= ysn_next;
            ycs_reg   <= ycs_next;
            slo_reg   <= s_next[qte_pkg::SLW-1:0];
            clamp_reg <= (s_next >= ONE_Q28) || (s_next <= -ONE_Q28);
            spos_reg  <= (s_next > 0);
        end
    end

    // ---- stage 3: sine squared ---------------------------------------------
    logic [qte_pkg::RW-1:0] sq_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_reg <= qte_pkg::RW'(slo_reg * slo_reg);
        end
    end

    // ---- square root: one result bit per stage ------------------------------
    logic [qte_pkg::RW-1:0] rem_init;
    logic [qte_pkg::RW-1:0] rem_reg [1:qte_pkg::SQRT_STAGES];
    logic [qte_pkg::RW-1:0] res_reg [1:qte_pkg::SQRT_STAGES];

    assign rem_init = (qte_pkg::RW'(1) << 56) - sq_reg;

    for (genvar k = 0; k < qte_pkg::SQRT_STAGES; k++) begin : g_sqrt
        localparam logic [qte_pkg::RW-1:0] BIT = qte_pkg::RW'(1) << (56 - 2 * k);
        logic [qte_pkg::RW-1:0] rem_cur, res_cur;
        logic [qte_pkg::RW-1:0] trial;
        if (k == 0) begin : g_first
            assign rem_cur = rem_init;
            assign res_cur = '0;
        end else begin : g_next
            assign rem_cur = rem_reg[k];
            assign res_cur = res_reg[k];
        end
        assign trial = res_cur + BIT;
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (rem_cur >= trial) begin
                    rem_reg[k+1] <= rem_cur - trial;
                    res_reg[k+1] <= (res_cur >> 1) + BIT;
                end else begin
                    rem_reg[k+1] <= rem_cur;
                    res_reg[k+1] <= res_cur >> 1;
                end
            end
        end
    end

    // ---- align roll, yaw and the sine with the root -------------------------
    qte_pkg::cxy_t rsn_dly [0:ALIGN-1];
    qte_pkg::cxy_t rcs_dly [0:ALIGN-1];
    qte_pkg::cxy_t ysn_dly [0:ALIGN-1];
    qte_pkg::cxy_t ycs_dly [0:ALIGN-1];
    qte_pkg::cxy_t s_dly   [0:ALIGN-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            rsn_dly[0] <= qte_pkg::CW'(rsn_reg);
            rcs_dly[0] <= qte_pkg::CW'(rcs_reg);
            ysn_dly[0] <= qte_pkg::CW'(ysn_reg);
            ycs_dly[0] <= qte_pkg::CW'(ycs_reg);
            s_dly[0]   <= qte_pkg::CW'(slo_reg);
            for (int j = 1; j < ALIGN; j++) begin
                rsn_dly[j] <= rsn_dly[j-1];
                rcs_dly[j] <= rcs_dly[j-1];
                ysn_dly[j] <= ysn_dly[j-1];
                ycs_dly[j] <= ycs_dly[j-1];
                s_dly[j]   <= s_dly[j-1];
            end
        end
    end

    // pole flag and sign ride alongside until the output stage
    localparam int FLAT = ALIGN + CLAT;
    logic [FLAT-1:0] clamp_dly, spos_dly;
    always_ff @(posedge aclk) begin
        if (ce) begin
            clamp_dly <= {clamp_dly[FLAT-2:0], clamp_reg};
            spos_dly  <= {spos_dly[FLAT-2:0], spos_reg};
        end
    end

    // ---- three CORDIC pipelines --------------------------------------------
    qte_pkg::cxy_t pcos;
    assign pcos = qte_pkg::CW'(res_reg[qte_pkg::SQRT_STAGES][qte_pkg::SLW-1:0]);

    logic signed [qte_pkg::AW-1:0] roll_a, pitch_a, yaw_a;

    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .aclk(aclk), .ce(ce),
        .y_in(rsn_dly[ALIGN-1]), .x_in(rcs_dly[ALIGN-1]), .angle(roll_a)
    );
    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .aclk(aclk), .ce(ce),
        .y_in(s_dly[ALIGN-1]), .x_in(pcos), .angle(pitch_a)
    );
    qte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .aclk(aclk), .ce(ce),
        .y_in(ysn_dly[ALIGN-1]), .x_in(ycs_dly[ALIGN-1]), .angle(yaw_a)
    );

    // ---- output stage: saturate, pole override ------------------------------
    localparam logic signed [qte_pkg::AW-1:0] PI_LIM = qte_pkg::AW'(qte_pkg::PI_Q13);
    localparam logic signed [qte_pkg::AW-1:0] HP_LIM = qte_pkg::AW'(qte_pkg::HALF_PI_Q13);

    logic signed [qte_pkg::AW-1:0] roll_next, pitch_next, yaw_next;
    logic signed [15:0] roll_reg, yaw_reg;
    logic signed [14:0] pitch_reg;
    logic               clamped_reg;

    always_comb begin
        roll_next = (roll_a > PI_LIM) ? PI_LIM : ((roll_a < -PI_LIM) ? -PI_LIM : roll_a);
        yaw_next  = (yaw_a > PI_LIM) ? PI_LIM : ((yaw_a < -PI_LIM) ? -PI_LIM : yaw_a);
        if (clamp_dly[FLAT-1]) begin
            pitch_next = spos_dly[FLAT-1] ? HP_LIM : -HP_LIM;
        end else begin
            pitch_next = (pitch_a > HP_LIM) ? HP_LIM
                       : ((pitch_a < -HP_LIM) ? -HP_LIM : pitch_a);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            roll_reg    <= roll_next[15:0];
            pitch_reg   <= pitch_next[14:0];
            yaw_reg     <= yaw_next[15:0];
            clamped_reg <= clamp_dly[FLAT-1];
        end
    end

    assign m_roll_angle    = roll_reg;
    assign m_pitch_angle   = pitch_reg;
    assign m_yaw_angle     = yaw_reg;
    assign m_pitch_clamped = clamped_reg;

endmodule

>>> src/qte_checker.sv
// ============================================================================
// qte_checker
// Port-level checks on the result channel, bound to the core.
// ============================================================================
module qte_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_roll_angle,
    input logic signed [14:0] m_pitch_angle,
    input logic signed [15:0] m_yaw_angle,
    input logic               m_pitch_clamped
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pitch_angle))
        else $error("result dropped while stalled");

    a_pole: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pitch_clamped |->
            (m_pitch_angle == 15'sd12868 || m_pitch_angle == -15'sd12868))
        else $error("clamped pitch not at pole");

    a_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle <= 15'sd12868 && m_pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    a_ry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll_angle <= 16'sd25736 && m_roll_angle >= -16'sd25736 &&
                     m_yaw_angle <= 16'sd25736 && m_yaw_angle >= -16'sd25736))
        else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_core qte_checker u_qte_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_roll_angle(m_roll_angle), .m_pitch_angle(m_pitch_angle),
    .m_yaw_angle(m_yaw_angle), .m_pitch_clamped(m_pitch_clamped)
);
